[rtl/assert_macros.svh]
// Assertion macros used by the converter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Consequent must hold a fixed number of cycles later.
`define ASSERT_DELAYED(label, clk, rst_n, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("assertion failed: delayed implication");

`endif

[rtl/jdc_pkg.sv]
// Types, constants and month table for the Julian day converter.
`timescale 1ns / 1ps
package jdc_pkg;

  typedef enum logic {
    JDC_OP_ENCODE = 1'b0,
    JDC_OP_DECODE = 1'b1
  } jdc_op_t;

  typedef struct packed {
    logic    valid;
    jdc_op_t op;
    logic    bad;
  } jdc_meta_t;

  // datapath register stages, equal for both directions
  localparam int JDC_DP_STAGES = 8;
  // start to strobe, including the output register
  localparam int JDC_LATENCY   = JDC_DP_STAGES + 1;

  localparam logic [13:0] JDC_YEAR_MAX   = 14'd9999;
  localparam logic [13:0] JDC_REFORM_YR  = 14'd1582;
  localparam logic [3:0]  JDC_MONTH_MAX  = 4'd12;
  localparam logic [3:0]  JDC_REFORM_MO  = 4'd10;
  localparam logic [4:0]  JDC_REFORM_DAY = 5'd15;

  localparam logic [22:0] JDC_DN_MIN    = 23'd1721424;
  localparam logic [22:0] JDC_DN_MAX    = 23'd5373484;
  localparam logic [22:0] JDC_REFORM_DN = 23'd2299161;

  // alpha = (4z - 7468865) / 146097 by reciprocal plus one correction step
  localparam logic [24:0] JDC_ALPHA_OFS   = 25'd7468865;
  localparam logic [17:0] JDC_ALPHA_DIV   = 18'd146097;
  localparam int          JDC_ALPHA_SHIFT = 41;
  localparam logic [23:0] JDC_ALPHA_RECIP = 24'((64'd1 << JDC_ALPHA_SHIFT) / 64'd146097);

  // c = (20b - 2442) / 7305, same scheme
  localparam logic [11:0] JDC_C_OFS   = 12'd2442;
  localparam logic [12:0] JDC_C_DIV   = 13'd7305;
  localparam int          JDC_C_SHIFT = 36;
  localparam logic [23:0] JDC_C_RECIP = 24'((64'd1 << JDC_C_SHIFT) / 64'd7305);

  // y / 100 for y below 16384
  localparam logic [12:0] JDC_HUND_RECIP = 13'd5243;
  localparam int          JDC_HUND_SHIFT = 19;

  localparam logic [12:0] JDC_YEAR_OFS = 13'd4716;
  localparam logic [10:0] JDC_DAY_OFS  = 11'd1524;

  // floor(30.6001 * k)
  function automatic logic [8:0] jdc_mfloor(input logic [3:0] k);
    logic [8:0] v;
    case (k)
      4'd1:    v = 9'd30;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd91;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd183;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd244;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd336;
      4'd12:   v = 9'd367;
      4'd13:   v = 9'd397;
      4'd14:   v = 9'd428;
      4'd15:   v = 9'd459;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/julian_day_converter_core.sv]
// Julian day converter: encode and decode pipelines with valid tracking.
// Path from start to out_valid: 8 datapath stages, then 1 output register.
// Throughput: one transaction per cycle; busy is held low, the pipeline never stalls.
// Reset clears all valid bits; transactions in flight at reset are dropped.
// Results appear for one cycle on out_valid; the receiver cannot stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module julian_day_converter_core import jdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [13:0] in_year_in,
  input  logic [3:0]  in_month_in,
  input  logic [4:0]  in_day_in,
  input  logic [22:0] in_day_number_in,
  output logic        out_valid,
  output logic [13:0] out_year_out,
  output logic [3:0]  out_month_out,
  output logic [4:0]  out_day_out,
  output logic [22:0] out_day_number_out,
  output logic        out_bad_input
);

  logic      accept;
  jdc_meta_t meta_nxt;
  jdc_meta_t meta_r [JDC_DP_STAGES];
  jdc_meta_t meta_last;

  logic [22:0] enc_dn;
  logic [13:0] dec_year;
  logic [3:0]  dec_month;
  logic [4:0]  dec_day;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    meta_nxt.valid = accept;
    meta_nxt.op    = jdc_op_t'(in_opcode);
    if (meta_nxt.op == JDC_OP_ENCODE) begin
      meta_nxt.bad = (in_year_in == 14'd0) || (in_year_in > JDC_YEAR_MAX) ||
                     (in_month_in == 4'd0) || (in_month_in > JDC_MONTH_MAX) ||
                     (in_day_in == 5'd0);
    end else begin
      meta_nxt.bad = (in_day_number_in < JDC_DN_MIN) || (in_day_number_in > JDC_DN_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < JDC_DP_STAGES; i++) begin
        meta_r[i].valid <= 1'b0;
      end
    end else begin
      meta_r[0] <= meta_nxt;
      for (int i = 1; i < JDC_DP_STAGES; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
    end
  end

  assign meta_last = meta_r[JDC_DP_STAGES-1];

  jdc_encode u_encode (
    .clk        (clk),
    .year       (in_year_in),
    .month      (in_month_in),
    .day        (in_day_in),
    .day_number (enc_dn)
  );

  jdc_decode u_decode (
    .clk        (clk),
    .day_number (in_day_number_in),
    .year       (dec_year),
    .month      (dec_month),
    .day        (dec_day)
  );

  // output register
  logic        out_valid_r;
  logic [13:0] out_year_r, out_year_nxt;
  logic [3:0]  out_month_r, out_month_nxt;
  logic [4:0]  out_day_r, out_day_nxt;
  logic [22:0] out_dn_r, out_dn_nxt;
  logic        out_bad_r;
  logic        is_dec, is_enc;

  always_comb begin
    is_dec        = !meta_last.bad && (meta_last.op == JDC_OP_DECODE);
    is_enc        = !meta_last.bad && (meta_last.op == JDC_OP_ENCODE);
    out_year_nxt  = is_dec ? dec_year  : 14'd0;
    out_month_nxt = is_dec ? dec_month : 4'd0;
    out_day_nxt   = is_dec ? dec_day   : 5'd0;
    out_dn_nxt    = is_enc ? enc_dn    : 23'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= meta_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_year_r  <= out_year_nxt;
    out_month_r <= out_month_nxt;
    out_day_r   <= out_day_nxt;
    out_dn_r    <= out_dn_nxt;
    out_bad_r   <= meta_last.bad;
  end

  assign out_valid          = out_valid_r;
  assign out_year_out       = out_year_r;
  assign out_month_out      = out_month_r;
  assign out_day_out        = out_day_r;
  assign out_day_number_out = out_dn_r;
  assign out_bad_input      = out_bad_r;

  // checks
  `ASSERT_DELAYED(a_latency, clk, rst_n, accept, JDC_LATENCY, out_valid)
  `ASSERT_IMPLIES(a_bad_zero, clk, rst_n, out_valid && out_bad_input, (out_year_out == 14'd0) && (out_month_out == 4'd0) && (out_day_out == 5'd0) && (out_day_number_out == 23'd0))
  `ASSERT_IMPLIES(a_one_dir, clk, rst_n, out_valid && (out_month_out != 4'd0), (out_day_number_out == 23'd0) && (out_month_out <= JDC_MONTH_MAX) && (out_day_out != 5'd0))

endmodule

[rtl/jdc_encode.sv]
// Pipelined civil date to day number encoder.
`timescale 1ns / 1ps
module jdc_encode import jdc_pkg::*; (
  input  logic        clk,
  input  logic [13:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  output logic [22:0] day_number
);

  localparam int DLY = JDC_DP_STAGES - 3;

  // stage 1
  logic [13:0] s1_y_nxt, s1_y_r;
  logic [3:0]  s1_m_nxt, s1_m_r;
  logic        s1_jul_nxt, s1_jul_r;
  logic [26:0] s1_pa_nxt, s1_pa_r;
  logic [4:0]  s1_d_r;

  always_comb begin
    s1_y_nxt   = (month <= 4'd2) ? year - 14'd1 : year;
    s1_m_nxt   = (month <= 4'd2) ? month + 4'd12 : month;
    s1_jul_nxt = (year < JDC_REFORM_YR) ||
                 ((year == JDC_REFORM_YR) && ((month < JDC_REFORM_MO) ||
                  ((month == JDC_REFORM_MO) && (day < JDC_REFORM_DAY))));
    s1_pa_nxt  = 27'(s1_y_nxt) * 27'(JDC_HUND_RECIP);
  end

  always_ff @(posedge clk) begin
    s1_y_r   <= s1_y_nxt;
    s1_m_r   <= s1_m_nxt;
    s1_jul_r <= s1_jul_nxt;
    s1_pa_r  <= s1_pa_nxt;
    s1_d_r   <= day;
  end

  // stage 2: century correction and the two scaled terms
  logic [7:0]  s2_a;
  logic [24:0] s2_p1;
  logic [7:0]  s2_bs_nxt, s2_bs_r;
  logic [22:0] s2_t1_nxt, s2_t1_r;
  logic [8:0]  s2_t2_nxt, s2_t2_r;
  logic [4:0]  s2_d_r;

  always_comb begin
    s2_a      = s1_pa_r[JDC_HUND_SHIFT +: 8];
    s2_bs_nxt = s1_jul_r ? 8'd0 : s2_a - (s2_a >> 2) - 8'd2;
    s2_p1     = (25'(s1_y_r) + 25'(JDC_YEAR_OFS)) * 25'd1461;
    s2_t1_nxt = s2_p1[24:2];
    s2_t2_nxt = jdc_mfloor(s1_m_r + 4'd1);
  end

  always_ff @(posedge clk) begin
    s2_bs_r <= s2_bs_nxt;
    s2_t1_r <= s2_t1_nxt;
    s2_t2_r <= s2_t2_nxt;
    s2_d_r  <= s1_d_r;
  end

  // stage 3: final sum
  logic [22:0] s3_jd_nxt, s3_jd_r;

  assign s3_jd_nxt = s2_t1_r + 23'(s2_t2_r) + 23'(s2_d_r) - 23'(JDC_DAY_OFS) - 23'(s2_bs_r);

  always_ff @(posedge clk) begin
    s3_jd_r <= s3_jd_nxt;
  end

  // align with the decoder
  logic [22:0] dly_r [DLY];

  always_ff @(posedge clk) begin
    dly_r[0] <= s3_jd_r;
    for (int i = 1; i < DLY; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  assign day_number = dly_r[DLY-1];

endmodule

[rtl/jdc_decode.sv]
// Pipelined day number to civil date decoder.
`timescale 1ns / 1ps
module jdc_decode import jdc_pkg::*; (
  input  logic        clk,
  input  logic [22:0] day_number,
  output logic [13:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day
);

  // stage 1: alpha numerator and reciprocal product
  logic        s1_greg_nxt, s1_greg_r;
  logic [24:0] s1_x4;
  logic [23:0] s1_xa_nxt, s1_xa_r;
  logic [47:0] s1_pa_nxt, s1_pa_r;
  logic [22:0] s1_z_r;

  always_comb begin
    s1_greg_nxt = day_number >= JDC_REFORM_DN;
    s1_x4       = (25'(day_number) << 2) - JDC_ALPHA_OFS;
    s1_xa_nxt   = s1_x4[23:0];
    s1_pa_nxt   = 48'(s1_xa_nxt) * 48'(JDC_ALPHA_RECIP);
  end

  always_ff @(posedge clk) begin
    s1_greg_r <= s1_greg_nxt;
    s1_xa_r   <= s1_xa_nxt;
    s1_pa_r   <= s1_pa_nxt;
    s1_z_r    <= day_number;
  end

  // stage 2: quotient estimate and remainder
  logic [6:0]  s2_q_nxt, s2_q_r;
  logic [24:0] s2_rem;
  logic [18:0] s2_r_nxt, s2_r_r;
  logic        s2_greg_r;
  logic [22:0] s2_z_r;

  always_comb begin
    s2_q_nxt = s1_pa_r[JDC_ALPHA_SHIFT +: 7];
    s2_rem   = 25'(s1_xa_r) - 25'(s2_q_nxt) * 25'(JDC_ALPHA_DIV);
    s2_r_nxt = s2_rem[18:0];
  end

  always_ff @(posedge clk) begin
    s2_q_r    <= s2_q_nxt;
    s2_r_r    <= s2_r_nxt;
    s2_greg_r <= s1_greg_r;
    s2_z_r    <= s1_z_r;
  end

  // stage 3: alpha, a, b and the year numerator
  logic [6:0]  s3_alpha;
  logic [22:0] s3_a;
  logic [22:0] s3_b_nxt, s3_b_r;
  logic [26:0] s3_nc_nxt, s3_nc_r;

  always_comb begin
    s3_alpha  = s2_q_r + 7'((s2_r_r >= 19'(JDC_ALPHA_DIV)) ? 1 : 0);
    s3_a      = s2_greg_r ?
                s2_z_r + 23'd1 + 23'(s3_alpha) - 23'(s3_alpha >> 2) : s2_z_r;
    s3_b_nxt  = s3_a + 23'(JDC_DAY_OFS);
    s3_nc_nxt = 27'(s3_b_nxt) * 27'd20 - 27'(JDC_C_OFS);
  end

  always_ff @(posedge clk) begin
    s3_b_r  <= s3_b_nxt;
    s3_nc_r <= s3_nc_nxt;
  end

  // stage 4: reciprocal product for c
  logic [50:0] s4_pc_nxt, s4_pc_r;
  logic [26:0] s4_nc_r;
  logic [22:0] s4_b_r;

  assign s4_pc_nxt = 51'(s3_nc_r) * 51'(JDC_C_RECIP);

  always_ff @(posedge clk) begin
    s4_pc_r <= s4_pc_nxt;
    s4_nc_r <= s3_nc_r;
    s4_b_r  <= s3_b_r;
  end

  // stage 5: estimate and remainder for c
  logic [14:0] s5_q_nxt, s5_q_r;
  logic [27:0] s5_rem;
  logic [13:0] s5_r_nxt, s5_r_r;
  logic [22:0] s5_b_r;

  always_comb begin
    s5_q_nxt = s4_pc_r[JDC_C_SHIFT +: 15];
    s5_rem   = 28'(s4_nc_r) - 28'(s5_q_nxt) * 28'(JDC_C_DIV);
    s5_r_nxt = s5_rem[13:0];
  end

  always_ff @(posedge clk) begin
    s5_q_r <= s5_q_nxt;
    s5_r_r <= s5_r_nxt;
    s5_b_r <= s4_b_r;
  end

  // stage 6: c, d and day within the shifted year
  logic [13:0] s6_c_nxt, s6_c_r;
  logic [24:0] s6_pd;
  logic [22:0] s6_diff;
  logic [8:0]  s6_bd_nxt, s6_bd_r;

  always_comb begin
    s6_c_nxt  = 14'(s5_q_r) + 14'((s5_r_r >= 14'(JDC_C_DIV)) ? 1 : 0);
    s6_pd     = 25'(s6_c_nxt) * 25'd1461;
    s6_diff   = s5_b_r - s6_pd[24:2];
    s6_bd_nxt = s6_diff[8:0];
  end

  always_ff @(posedge clk) begin
    s6_c_r  <= s6_c_nxt;
    s6_bd_r <= s6_bd_nxt;
  end

  // stage 7: month index e by threshold compares
  logic [3:0]  s7_e_nxt, s7_e_r;
  logic [8:0]  s7_bd_r;
  logic [13:0] s7_c_r;

  always_comb begin
    s7_e_nxt = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (s6_bd_r > jdc_mfloor(4'(k))) begin
        s7_e_nxt = 4'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    s7_e_r  <= s7_e_nxt;
    s7_bd_r <= s6_bd_r;
    s7_c_r  <= s6_c_r;
  end

  // stage 8: day, month, year
  logic [8:0]  s8_dy;
  logic [3:0]  s8_mo_nxt, s8_mo_r;
  logic [4:0]  s8_dy_nxt, s8_dy_r;
  logic [13:0] s8_yr_nxt, s8_yr_r;

  always_comb begin
    s8_dy     = s7_bd_r - jdc_mfloor(s7_e_r);
    s8_dy_nxt = s8_dy[4:0];
    s8_mo_nxt = (s7_e_r < 4'd14) ? s7_e_r - 4'd1 : s7_e_r - 4'd13;
    s8_yr_nxt = (s8_mo_nxt > 4'd2) ? s7_c_r - 14'(JDC_YEAR_OFS)
                                   : s7_c_r - 14'(JDC_YEAR_OFS - 13'd1);
  end

  always_ff @(posedge clk) begin
    s8_mo_r <= s8_mo_nxt;
    s8_dy_r <= s8_dy_nxt;
    s8_yr_r <= s8_yr_nxt;
  end

  assign year  = s8_yr_r;
  assign month = s8_mo_r;
  assign day   = s8_dy_r;

endmodule
